>>> hdl/plil_pkg.sv
// ----------------------------------------------------------------------------
// plil_pkg - positional list insert/remove shared definitions
// Field widths, command and status codes, and the control word that is
// broadcast to every cell of the list.
// ----------------------------------------------------------------------------
package plil_pkg;

  localparam int unsigned DefaultDepth = 16;

  localparam int unsigned CmdW    = 1;
  localparam int unsigned PosW    = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  typedef enum logic [CmdW-1:0] {
    CmdInsert = 1'b0,
    CmdRemove = 1'b1
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StOk     = 2'd0,
    StFull   = 2'd1,
    StEmpty  = 2'd2,
    StBadPos = 2'd3
  } status_e;

  // Broadcast to all cells for one transfer
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [PosW-1:0]   pos;
    logic [DataW-1:0]  value;
  } cell_ctrl_t;

endpackage

>>> hdl/plil_in_if.sv
// ----------------------------------------------------------------------------
// plil_in_if - command channel
// Valid/ready channel carrying one insert or remove command.
// ----------------------------------------------------------------------------
interface plil_in_if;
  logic                                valid;
  logic                                ready;
  logic [plil_pkg::CmdW-1:0]           command;
  logic [plil_pkg::PosW-1:0]           position;
  logic signed [plil_pkg::DataW-1:0]   value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

>>> hdl/plil_out_if.sv
// ----------------------------------------------------------------------------
// plil_out_if - result channel
// Valid/ready channel carrying one result per command.
// ----------------------------------------------------------------------------
interface plil_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [plil_pkg::DataW-1:0]   removed_value;
  logic [plil_pkg::StatusW-1:0]        status;
  logic [plil_pkg::CountW-1:0]         count;

  modport source (output valid, removed_value, status, count, input ready);
  modport sink   (input valid, removed_value, status, count, output ready);
endinterface

>>> hdl/plil_cell.sv
// ----------------------------------------------------------------------------
// plil_cell - one list slot
// Holds the entry at list position Idx+1 and shifts with its neighbours.
// ----------------------------------------------------------------------------
module plil_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                              clk_i,
  input  plil_pkg::cell_ctrl_t              ctrl_i,
  input  logic [plil_pkg::DataW-1:0]        prev_i,
  input  logic [plil_pkg::DataW-1:0]        next_i,
  output logic [plil_pkg::DataW-1:0]        data_o,
  output logic [plil_pkg::DataW-1:0]        sel_o
);

  localparam int unsigned CellPos = Idx + 1;

  logic [plil_pkg::DataW-1:0] data_q, data_d;
  logic                       is_at, is_after;

  assign is_at    = (32'(ctrl_i.pos) == CellPos);
  assign is_after = (32'(ctrl_i.pos) <  CellPos);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (is_at)         data_d = ctrl_i.value;
      else if (is_after) data_d = prev_i;
    end else if (ctrl_i.rem) begin
      // take the follower's entry from the removed slot onwards
      if (is_at || is_after) data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign sel_o  = is_at ? data_q : '0;

endmodule

>>> hdl/positional_list_insert_remove_unit.sv
// ----------------------------------------------------------------------------
// positional_list_insert_remove_unit - ordered list with positional edits
// Keeps up to Depth signed 32-bit entries in a row of shifting cells.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                           | transfer on
//  --------+-----+-----------------------------------+-----------------------
//  in_i    | in  | command, position, value          | valid & ready
//  out_o   | out | removed_value, status, count      | valid & ready
//
//  One command per cycle while results drain: every cell shifts in
//  parallel, so a command is finished in the cycle it is taken and its
//  result sits in the output register from the next cycle on.
//  Reset clears the entry count and the result valid; cell contents are
//  left as they are and only slots below the count are ever read.
//  A stalled result holds in the output register; a new command is still
//  taken in the cycle that result leaves.
// ----------------------------------------------------------------------------
module positional_list_insert_remove_unit #(
  parameter int unsigned Depth = plil_pkg::DefaultDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  plil_in_if.sink    in_i,
  plil_out_if.source out_o
);

  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned CmpW   = ((CntW > plil_pkg::PosW) ? CntW : plil_pkg::PosW) + 1;

  localparam logic [CmpW-1:0] DepthW = CmpW'(Depth);
  localparam logic [CmpW-1:0] OneW   = CmpW'(1);

  // ---- list state ----------------------------------------------------------
  logic [CntW-1:0] cnt_q, cnt_d;

  // ---- result register -----------------------------------------------------
  logic                                out_vld_q;
  logic [plil_pkg::DataW-1:0]          out_rval_q, out_rval_d;
  plil_pkg::status_e                   out_st_q, out_st_d;
  logic [plil_pkg::CountW-1:0]         out_cnt_q, out_cnt_d;

  logic                                accept;
  logic                                ins_ok, rem_ok;
  logic [CmpW-1:0]                     pos_w, cnt_w, cnt_next_w;
  plil_pkg::cell_ctrl_t                ctrl;
  logic [plil_pkg::DataW-1:0]          cell_data [Depth];
  logic [plil_pkg::DataW-1:0]          cell_sel  [Depth];
  logic [plil_pkg::DataW-1:0]          picked;

  // Take a command whenever the result register is empty or being drained
  assign in_i.ready = !out_vld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign pos_w = CmpW'(in_i.position);
  assign cnt_w = CmpW'(cnt_q);

  // Decide the status; full and empty win over a bad position
  always_comb begin
    ins_ok   = 1'b0;
    rem_ok   = 1'b0;
    out_st_d = plil_pkg::StOk;
    if (plil_pkg::cmd_e'(in_i.command) == plil_pkg::CmdInsert) begin
      if (cnt_w >= DepthW)                                out_st_d = plil_pkg::StFull;
      else if (pos_w == '0 || pos_w > (cnt_w + OneW))     out_st_d = plil_pkg::StBadPos;
      else                                                ins_ok   = 1'b1;
    end else begin
      if (cnt_w == '0)                                    out_st_d = plil_pkg::StEmpty;
      else if (pos_w == '0 || pos_w > cnt_w)              out_st_d = plil_pkg::StBadPos;
      else                                                rem_ok   = 1'b1;
    end
  end

  // Broadcast the edit to the cells only for a taken, valid command
  always_comb begin
    ctrl.ins   = accept && ins_ok;
    ctrl.rem   = accept && rem_ok;
    ctrl.pos   = in_i.position;
    ctrl.value = in_i.value;
  end

  // ---- cell row --------------------------------------------------------------
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [plil_pkg::DataW-1:0] prev_d, next_d;

    if (i == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_mid_prev
      assign prev_d = cell_data[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_mid_next
      assign next_d = cell_data[i+1];
    end

    plil_cell #(.Idx(i)) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .prev_i (prev_d),
      .next_i (next_d),
      .data_o (cell_data[i]),
      .sel_o  (cell_sel[i])
    );
  end

  // At most one cell matches the position: merge by OR. Positions are five
  // bits wide, so cells past the 31st never match and fold away to zero.
  always_comb begin
    picked = '0;
    for (int unsigned k = 0; k < Depth; k++) begin
      picked = picked | cell_sel[k];
    end
  end

  // ---- count and result ------------------------------------------------------
  always_comb begin
    cnt_next_w = cnt_w;
    if (ins_ok)      cnt_next_w = cnt_w + OneW;
    else if (rem_ok) cnt_next_w = cnt_w - OneW;
    cnt_d      = accept ? cnt_next_w[CntW-1:0] : cnt_q;
    out_cnt_d  = cnt_next_w[plil_pkg::CountW-1:0];
    out_rval_d = rem_ok ? picked : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept)           out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  // Payload: load on every taken command, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_rval_q <= out_rval_d;
      out_st_q   <= out_st_d;
      out_cnt_q  <= out_cnt_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.removed_value = out_rval_q;
  assign out_o.status        = out_st_q;
  assign out_o.count         = out_cnt_q;

  // ---- assertions ------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= Depth)
    else $error("entry count above depth");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ins_ok) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("insert did not grow the list by one");

  a_fail_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !ins_ok && !rem_ok) |=> $stable(cnt_q))
    else $error("failed command changed the count");

  a_rval_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !rem_ok) |=> (out_rval_q == '0))
    else $error("removed value set without a remove");

  a_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (ins_ok || rem_ok)) |=> (out_st_q == plil_pkg::StOk))
    else $error("successful command without ok status");

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - positional list insert/remove regression
// Drives insert and remove commands through the command channel and checks
// every result against a typed-in result or a behavioural copy of the list:
// a short table of edge cases first, then a long random run whose phases
// alternately fill and drain the list. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ListDepth = plil_pkg::DefaultDepth;

  typedef logic [plil_pkg::PosW-1:0]          pos_t;
  typedef logic [plil_pkg::CountW-1:0]        count_t;
  typedef logic signed [plil_pkg::DataW-1:0]  word_t;

  // One command as offered on the command channel
  typedef struct {
    plil_pkg::cmd_e    cmd;
    pos_t              pos;
    word_t             value;
  } list_cmd_t;

  // One result as the block should return it
  typedef struct {
    word_t             removed;
    plil_pkg::status_e status;
    count_t            count;
  } list_result_t;

  // Directed row: the command, and where obvious the result typed in by hand
  typedef struct {
    plil_pkg::cmd_e    cmd;
    pos_t              pos;
    word_t             value;
    bit                known;
    word_t             removed;
    plil_pkg::status_e status;
    count_t            count;
  } plan_row_t;

  localparam int PlanRows    = 28;
  localparam int RandomItems = 1300;

  logic clk;
  logic rst_n;

  plil_in_if  cmd_ch ();
  plil_out_if res_ch ();

  positional_list_insert_remove_unit #(
    .Depth(ListDepth)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (cmd_ch),
    .out_o (res_ch)
  );

  // Bench copy of the list: cells below list_len are the live entries
  word_t list_cells [ListDepth];
  int    list_len;

  // Results owed by the block, oldest first
  list_result_t awaited_results [$];
  int           errors;

  // Empty-list and bad-position cases first, then a fill to the brim with
  // edits at the front, the back and the middle, then the full-list and
  // out-of-range removes, and a remove at each end.
  plan_row_t directed_plan [PlanRows] = '{
    '{plil_pkg::CmdRemove, 5'd0,  32'sd0,         1'b1, 32'sd0,         plil_pkg::StEmpty,  5'd0},
    '{plil_pkg::CmdInsert, 5'd0,  32'sd5,         1'b1, 32'sd0,         plil_pkg::StBadPos, 5'd0},
    '{plil_pkg::CmdInsert, 5'd2,  32'sd5,         1'b1, 32'sd0,         plil_pkg::StBadPos, 5'd0},
    '{plil_pkg::CmdInsert, 5'd1,  32'sh7FFF_FFFF, 1'b1, 32'sd0,         plil_pkg::StOk,     5'd1},
    '{plil_pkg::CmdRemove, 5'd2,  32'sd0,         1'b1, 32'sd0,         plil_pkg::StBadPos, 5'd1},
    '{plil_pkg::CmdRemove, 5'd1,  32'sd0,         1'b1, 32'sh7FFF_FFFF, plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdInsert, 5'd1,  32'sh8000_0000, 1'b0, 32'sd0,         plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdInsert, 5'd1,  -32'sd1,        1'b0, 32'sd0,         plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdInsert, 5'd3,  32'sd0,         1'b0, 32'sd0,         plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdInsert, 5'd2,  32'sh5A5A_5A5A, 1'b0, 32'sd0,         plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdInsert, 5'd5,  32'sh7FFF_FFFF, 1'b0, 32'sd0,         plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdInsert, 5'd1,  32'sd1,         1'b0, 32'sd0,         plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdInsert, 5'd4,  32'shA5A5_A5A5, 1'b0, 32'sd0,         plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdInsert, 5'd8,  32'sh1234_5678, 1'b0, 32'sd0,         plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdInsert, 5'd2,  32'sh0F0F_0F0F, 1'b0, 32'sd0,         plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdInsert, 5'd10, 32'shF0F0_F0F0, 1'b0, 32'sd0,         plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdInsert, 5'd6,  32'sh3333_3333, 1'b0, 32'sd0,         plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdInsert, 5'd12, 32'shCCCC_CCCC, 1'b0, 32'sd0,         plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdInsert, 5'd7,  32'sh5555_5555, 1'b0, 32'sd0,         plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdInsert, 5'd14, 32'shAAAA_AAAA, 1'b0, 32'sd0,         plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdInsert, 5'd3,  32'sh00FF_00FF, 1'b0, 32'sd0,         plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdInsert, 5'd16, 32'shFF00_FF00, 1'b0, 32'sd0,         plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdInsert, 5'd31, 32'sd9,         1'b1, 32'sd0,         plil_pkg::StFull,   5'd16},
    '{plil_pkg::CmdRemove, 5'd0,  32'sd0,         1'b1, 32'sd0,         plil_pkg::StBadPos, 5'd16},
    '{plil_pkg::CmdRemove, 5'd17, 32'sd0,         1'b1, 32'sd0,         plil_pkg::StBadPos, 5'd16},
    '{plil_pkg::CmdRemove, 5'd16, 32'sd0,         1'b0, 32'sd0,         plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdRemove, 5'd1,  32'sd0,         1'b0, 32'sd0,         plil_pkg::StOk,     5'd0},
    '{plil_pkg::CmdRemove, 5'd31, 32'sd0,         1'b1, 32'sd0,         plil_pkg::StBadPos, 5'd14}
  };

  // Apply one command to the bench copy and return the result it gives.
  // Full and empty take priority over a bad position; a failed command
  // leaves the list untouched.
  function automatic list_result_t edit_list(list_cmd_t c);
    list_result_t r;
    int           p;
    int           k;
    p         = int'(c.pos);
    r.removed = '0;
    r.status  = plil_pkg::StOk;
    if (c.cmd == plil_pkg::CmdInsert) begin
      if (list_len >= ListDepth) begin
        r.status = plil_pkg::StFull;
      end else if (p < 1 || p > list_len + 1) begin
        r.status = plil_pkg::StBadPos;
      end else begin
        // open a gap at p by moving later entries back one place
        for (k = list_len; k >= p; k--) list_cells[k] = list_cells[k-1];
        list_cells[p-1] = c.value;
        list_len++;
      end
    end else begin
      if (list_len == 0) begin
        r.status = plil_pkg::StEmpty;
      end else if (p < 1 || p > list_len) begin
        r.status = plil_pkg::StBadPos;
      end else begin
        r.removed = list_cells[p-1];
        // close the gap by moving later entries forward
        for (k = p; k < list_len; k++) list_cells[k-1] = list_cells[k];
        list_len--;
      end
    end
    r.count = count_t'(list_len);
    return r;
  endfunction

  // Draw a random command that is mostly well formed for the current list.
  // Phases of 64 commands alternate between filling and draining so that
  // both the full and the empty list are reached again and again.
  function automatic list_cmd_t draw_command(int n);
    list_cmd_t c;
    int        ins_pct;
    int        hi;
    ins_pct = ((n / 64) % 2 == 0) ? 75 : 25;
    c.cmd   = ($urandom_range(99) < ins_pct) ? plil_pkg::CmdInsert : plil_pkg::CmdRemove;
    hi      = (c.cmd == plil_pkg::CmdInsert) ? list_len + 1 : list_len;
    if (hi < 1) hi = 1;
    if (hi > 31) hi = 31;
    case ($urandom_range(7))
      0:       c.pos = pos_t'($urandom_range(31));   // noise: any position
      1:       c.pos = 5'd1;                         // front
      2:       c.pos = pos_t'(hi);                   // back
      3:       c.pos = pos_t'(hi + 1);               // just past the end
      default: c.pos = pos_t'($urandom_range(hi, 1));
    endcase
    case ($urandom_range(7))
      0:       c.value = 32'sh7FFF_FFFF;
      1:       c.value = 32'sh8000_0000;
      2:       c.value = -32'sd1;
      3:       c.value = 32'sd0;
      default: c.value = $urandom;
    endcase
    return c;
  endfunction

  // Idle gap per transfer; every so often a burst with no gaps at all
  function automatic int draw_gap(int n, int period, int offset);
    if (((n + offset) % period) < period / 4) return 0;
    return $urandom_range(11);
  endfunction

  // Offer one command, hold it until the block takes it, then log what the
  // block owes for it. A typed-in result replaces the predicted one, but
  // the bench copy is advanced either way.
  task automatic send_command(list_cmd_t c, int n, bit known, list_result_t typed);
    list_result_t r;
    int           gap;
    gap = draw_gap(n, 200, 0);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.command  <= c.cmd;
    cmd_ch.position <= c.pos;
    cmd_ch.value    <= c.value;
    do @(posedge clk); while (!cmd_ch.ready);
    r = edit_list(c);
    awaited_results.push_back(known ? typed : r);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up if the run hangs; the slowest honest run is far below this
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: stall at random, then check each transfer against the
  // oldest result still owed.
  initial begin : result_checker
    list_result_t want;
    int           taken;
    int           gap;
    taken        = 0;
    res_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      gap = draw_gap(taken, 170, 60);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      taken++;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed: removed %0d status %0d count %0d",
                 $time, res_ch.removed_value, res_ch.status, res_ch.count);
      end else begin
        want = awaited_results.pop_front();
        if (res_ch.removed_value !== want.removed) begin
          errors++;
          $display("%0t: removed_value expected %0d actual %0d",
                   $time, want.removed, res_ch.removed_value);
        end
        if (res_ch.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, res_ch.status);
        end
        if (res_ch.count !== want.count) begin
          errors++;
          $display("%0t: count expected %0d actual %0d",
                   $time, want.count, res_ch.count);
        end
      end
    end
  end

  // Command side: reset, directed table, random run, drain, verdict
  initial begin : command_driver
    list_cmd_t    c;
    list_result_t typed;
    int           n;
    int           hold;
    errors          = 0;
    list_len        = 0;
    rst_n           = 1'b0;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.command  <= plil_pkg::CmdInsert;
    cmd_ch.position <= '0;
    cmd_ch.value    <= '0;

    // hold reset, then release it on an edge
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    for (n = 0; n < PlanRows; n++) begin
      c.cmd         = directed_plan[n].cmd;
      c.pos         = directed_plan[n].pos;
      c.value       = directed_plan[n].value;
      typed.removed = directed_plan[n].removed;
      typed.status  = directed_plan[n].status;
      typed.count   = directed_plan[n].count;
      send_command(c, n, directed_plan[n].known, typed);
    end

    // random run, checked against the bench copy alone
    for (n = 0; n < RandomItems; n++) begin
      c = draw_command(n);
      send_command(c, n + PlanRows, 1'b0, typed);
    end
    cmd_ch.valid <= 1'b0;

    // drain what is owed, then wait for anything stray
    hold = 0;
    while (awaited_results.size() != 0 && hold < 2000) begin
      @(posedge clk);
      hold++;
    end
    if (awaited_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
    end
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> positional_list_insert_remove_unit.f
hdl/plil_pkg.sv
hdl/plil_in_if.sv
hdl/plil_out_if.sv
hdl/plil_cell.sv
hdl/positional_list_insert_remove_unit.sv
test/testbench.sv
